// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int unsigned DEPTH    = 16;
    localparam int unsigned AW       = $clog2(DEPTH);
    localparam int unsigned CW       = $clog2(DEPTH + 1);
    localparam int unsigned PRIO_W   = 8;
    localparam int unsigned SEQ_W    = 32;
    localparam int unsigned ENTRY_W  = PRIO_W + SEQ_W;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } t_func;

    typedef struct packed {
        t_func             func;
        logic [PRIO_W-1:0] prio_in;
    } t_in_word;

    typedef struct packed {
        logic              ok;
        logic [PRIO_W-1:0] prio_out;
    } t_out_word;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [SEQ_W-1:0]  seq;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_PLACE,
        ST_DONE
    } t_state;

endpackage

// ===== sv/spq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/stable_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue kept as a sorted array in one RAM, highest first,
// arrival order among equal priorities.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Word
// cmd      in         i_start & !o_busy  i_cmd   (func, prio_in)
// result   out        o_strobe           o_res   (ok, prio_out)
//
// A refused item goes straight to the result. A pop reads from the head and
// moves every remaining entry up one place. A push into an empty queue writes
// the item at once; else entries of lower priority move down one place from
// the tail, then the item is placed. Each moved entry is one read, one write.
// Reset clears occupancy and the sequence counter; the RAM needs no clear.
// The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module stable_priority_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  spq_pkg::t_in_word  i_cmd,
    output logic               o_busy,
    output logic               o_strobe,
    output spq_pkg::t_out_word o_res
);
    import spq_pkg::*;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [SEQ_W-1:0]  r_seq, n_seq;
    logic [AW-1:0]     r_pos, n_pos;
    t_func             r_func;
    logic [PRIO_W-1:0] r_prio;
    logic              r_ok, n_ok;
    logic [PRIO_W-1:0] r_pout, n_pout;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    t_entry            wdata, rdata;
    logic              accept;
    logic              full, empty;

    assign accept = i_start && (r_state == ST_IDLE);
    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);

    spq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_count = r_count;
        n_seq   = r_seq;
        n_ok    = r_ok;
        n_pout  = r_pout;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_pout = '0;
                    if (i_cmd.func == FUNC_PUSH) begin
                        n_ok = !full;
                        if (full) begin
                            n_state = ST_DONE;
                        end else if (empty) begin
                            n_pos   = '0;
                            n_state = ST_PLACE;
                        end else begin
                            // read the tail entry first
                            n_pos   = AW'(r_count - CW'(1));
                            n_state = ST_READ;
                        end
                    end else begin
                        n_ok  = !empty;
                        n_pos = '0;
                        n_state = empty ? ST_DONE : ST_READ;
                    end
                end
            end
            ST_READ: begin
                // read of r_pos is issued this cycle
                n_state = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (r_func == FUNC_PUSH) begin
                    if (rdata.prio < r_prio) begin
                        // entry moved down; continue upward
                        if (r_pos == '0) begin
                            n_state = ST_PLACE;
                        end else begin
                            n_pos   = r_pos - AW'(1);
                        end
                    end else begin
                        n_pos   = r_pos + AW'(1);
                        n_state = ST_PLACE;
                    end
                end else begin
                    if (r_pos == '0) begin
                        n_pout = rdata.prio;
                    end
                    if (CW'(r_pos) + CW'(1) >= r_count) begin
                        n_count = r_count - CW'(1);
                        n_state = ST_DONE;
                    end else begin
                        n_pos = r_pos + AW'(1);
                    end
                end
            end
            ST_PLACE: begin
                n_count = r_count + CW'(1);
                n_seq   = r_seq + SEQ_W'(1);
                n_state = ST_DONE;
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // RAM control and outputs
    always_comb begin
        we    = 1'b0;
        waddr = r_pos;
        wdata = rdata;
        raddr = n_pos;
        unique case (r_state)
            ST_SHIFT: begin
                if (r_func == FUNC_PUSH) begin
                    if (rdata.prio < r_prio) begin
                        we    = 1'b1;
                        waddr = r_pos + AW'(1);
                    end
                end else if (r_pos != '0) begin
                    we    = 1'b1;
                    waddr = r_pos - AW'(1);
                end
            end
            ST_PLACE: begin
                we         = 1'b1;
                wdata.prio = r_prio;
                wdata.seq  = r_seq;
            end
            default: ;
        endcase
        o_busy   = (r_state != ST_IDLE);
        o_strobe = (r_state == ST_DONE);
        o_res.ok       = r_ok;
        o_res.prio_out = r_pout;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_seq   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_seq   <= n_seq;
        end
    end

    // hold the command word and result
    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_ok   <= n_ok;
        r_pout <= n_pout;
        if (accept) begin
            r_func <= i_cmd.func;
            r_prio <= i_cmd.prio_in;
        end
    end

endmodule

// ===== sv/spq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the queue's command and result words.
// ----------------------------------------------------------------------------
module spq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input spq_pkg::t_in_word  i_cmd,
    input logic               o_busy,
    input logic               o_strobe,
    input spq_pkg::t_out_word o_res
);
    import spq_pkg::*;

    // accepted word raises busy next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy not raised after accept");

    // result drops busy
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_busy)
        else $error("busy held after result");

    // strobe is a single cycle
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    // refused result carries zero priority
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.ok) |-> (o_res.prio_out == '0))
        else $error("refused result with nonzero priority");

    // no result while idle
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> !o_strobe)
        else $error("result while idle");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);
